FILE: sv/tqpc_pkg.sv
// ----------------------------------------------------------------------------
// tqpc_pkg
// Types and constants shared by the transmit queue completion block.
// ----------------------------------------------------------------------------
package tqpc_pkg;

  localparam int LEN_BITS  = 16;
  localparam int BYTE_W    = 22;
  localparam int CNT_OUT_W = 7;

  localparam logic [BYTE_W-1:0] PEND_MAX = 22'h3FFFFF;

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REPORT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [LEN_BITS-1:0] msg_len;
    logic [BYTE_W-1:0]   byte_count;
  } in_item_t;

  typedef struct packed {
    logic                 accepted;
    logic [CNT_OUT_W-1:0] released_count;
    logic [CNT_OUT_W-1:0] queued_count;
    logic [BYTE_W-1:0]    pending_bytes;
    logic [LEN_BITS-1:0]  head_offset_out;
  } out_item_t;

endpackage

FILE: sv/tx_queue_partial_completion.sv
// ----------------------------------------------------------------------------
// tx_queue_partial_completion
// Transmit queue of message lengths with partial completion tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carries requests: add a message length, report
//   sent bytes, or clear the queue. out_valid/out_stall/out_data returns one
//   result per request with the queue state after that request.
//   Add, clear and unused codes: the request moves the state from idle to
//   done, the result register loads as done is left, and the next request
//   is taken back in idle. Sent-bytes report: the walk reads the length
//   memory one entry per cycle from the head, examining the messages popped
//   plus any partly sent head, then goes to done as above. The single read
//   port of the length memory sets this pace.
//   Reset empties the queue at once; the length memory is not cleared.
//   A stalled result stays in the output register; the next request is taken
//   and worked on meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module tx_queue_partial_completion #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tqpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tqpc_pkg::out_item_t out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TOT_W = tqpc_pkg::LEN_BITS + CNT_W;
  localparam int CMP_W = (TOT_W > tqpc_pkg::BYTE_W) ? TOT_W : tqpc_pkg::BYTE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [PTR_W-1:0]                head_r, head_nxt;
  logic [PTR_W-1:0]                tail_r, tail_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [tqpc_pkg::LEN_BITS-1:0]   offset_r, offset_nxt;
  logic [TOT_W-1:0]                total_r, total_nxt;
  logic [tqpc_pkg::BYTE_W-1:0]     bytes_r, bytes_nxt;
  logic [CNT_W-1:0]                rel_r, rel_nxt;
  logic                            acc_r, acc_nxt;
  logic                            out_valid_r, out_valid_nxt;
  tqpc_pkg::out_item_t             out_data_r, out_data_nxt;

  logic                            in_xfer;
  logic                            wr_en;
  logic [PTR_W-1:0]                rd_addr;
  logic [tqpc_pkg::LEN_BITS-1:0]   rd_data;
  logic [PTR_W-1:0]                head_inc;
  logic [PTR_W-1:0]                tail_inc;
  logic [tqpc_pkg::LEN_BITS-1:0]   rest;
  logic [tqpc_pkg::BYTE_W-1:0]     rest_ext;
  logic [CMP_W-1:0]                total_ext;
  logic [tqpc_pkg::BYTE_W-1:0]     pending;
  logic                            out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;

  // read ahead the next head while walking so its length is ready after a pop
  assign rd_addr = (state_r == S_WALK) ? head_inc : head_r;
  assign wr_en   = in_xfer && (in_data.req_type == tqpc_pkg::REQ_ADD) &&
                   (count_r != CNT_W'(QUEUE_DEPTH));

  tqpc_ram #(
    .WIDTH (tqpc_pkg::LEN_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_data.msg_len),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rest     = rd_data - offset_r;
  assign rest_ext = tqpc_pkg::BYTE_W'(rest);

  // pending bytes saturate at the field maximum
  assign total_ext = CMP_W'(total_r);
  assign pending   = (total_ext > CMP_W'(tqpc_pkg::PEND_MAX)) ? tqpc_pkg::PEND_MAX
                                                              : tqpc_pkg::BYTE_W'(total_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    offset_nxt    = offset_r;
    total_nxt     = total_r;
    bytes_nxt     = bytes_r;
    rel_nxt       = rel_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          rel_nxt   = '0;
          acc_nxt   = 1'b1;
          state_nxt = S_DONE;
          case (in_data.req_type)
            tqpc_pkg::REQ_ADD: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                acc_nxt = 1'b0;
              end else begin
                tail_nxt  = tail_inc;
                count_nxt = count_r + 1'b1;
                total_nxt = total_r + TOT_W'(in_data.msg_len);
              end
            end
            tqpc_pkg::REQ_REPORT: begin
              bytes_nxt = in_data.byte_count;
              if (count_r != '0 && in_data.byte_count != '0) begin
                state_nxt = S_WALK;
              end
            end
            tqpc_pkg::REQ_CLEAR: begin
              head_nxt   = '0;
              tail_nxt   = '0;
              count_nxt  = '0;
              offset_nxt = '0;
              total_nxt  = '0;
            end
            default: begin
              acc_nxt = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        if (rest_ext > bytes_r) begin
          // head message only partly sent
          offset_nxt = offset_r + tqpc_pkg::LEN_BITS'(bytes_r);
          total_nxt  = total_r - TOT_W'(bytes_r);
          bytes_nxt  = '0;
          state_nxt  = S_DONE;
        end else begin
          bytes_nxt  = bytes_r - rest_ext;
          total_nxt  = total_r - TOT_W'(rest);
          head_nxt   = head_inc;
          count_nxt  = count_r - 1'b1;
          offset_nxt = '0;
          rel_nxt    = rel_r + 1'b1;
          if (count_r == CNT_W'(1) || bytes_r == rest_ext) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.accepted        = acc_r;
          out_data_nxt.released_count  = tqpc_pkg::CNT_OUT_W'(rel_r);
          out_data_nxt.queued_count    = tqpc_pkg::CNT_OUT_W'(count_r);
          out_data_nxt.pending_bytes   = pending;
          out_data_nxt.head_offset_out = offset_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      offset_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      offset_r    <= offset_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    rel_r      <= rel_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // occupancy never passes the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  // the walk only runs with entries left and bytes to spend
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> (count_r != '0 && bytes_r != '0))
    else $error("walk on empty queue or spent report");

  // a partly sent head implies a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    offset_r != '0 |-> count_r != '0)
    else $error("head offset set on empty queue");

  // a request transfer always leaves idle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("request transfer did not start work");

endmodule

FILE: sv/tqpc_ram.sv
// ----------------------------------------------------------------------------
// tqpc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tqpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the transmit queue completion block transfer by transfer against an
// in-bench model of the length queue. A table of directed requests hits the
// empty and full queue, zero-length messages and oversize reports. Random
// request mixes then follow under several sender and receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD     = 4;
  localparam int QDEPTH         = 64;
  localparam int LAT_MAX        = QDEPTH + 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_PH   = 300;
  localparam int NUM_PHASES     = 5;
  localparam int MAX_PRINTS     = 60;

  localparam logic [1:0]                  REQ_UNUSED = 2'd3;
  localparam logic [tqpc_pkg::BYTE_W-1:0] BYTE_MAX   = 22'h3FFFFF;

  typedef struct {
    tqpc_pkg::in_item_t  req;
    int                  reps;
    bit                  typed;
    tqpc_pkg::out_item_t want;
  } dir_row_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  tqpc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  tqpc_pkg::out_item_t out_data;

  // model of the queue
  logic [tqpc_pkg::LEN_BITS-1:0] msg_len_mem [QDEPTH];
  logic [5:0]                    head_idx     = '0;
  logic [6:0]                    msg_cnt      = '0;
  logic [tqpc_pkg::LEN_BITS-1:0] head_sent    = '0;
  logic [tqpc_pkg::BYTE_W-1:0]   unsent_bytes = '0;
  tqpc_pkg::out_item_t           status_q [$];

  // directed rows may carry a status typed in by hand
  bit                  row_typed = 1'b0;
  tqpc_pkg::out_item_t row_want  = '0;

  int gap_pct   = 0;
  int stall_pct = 0;
  int n_errors  = 0;
  int n_reqs    = 0;
  int n_status  = 0;
  int n_refused = 0;
  int n_partial = 0;
  int max_freed = 0;
  int idle_cycles = 0;

  int gap_tab   [NUM_PHASES] = '{0, 68, 0, 24, 0};
  int stall_tab [NUM_PHASES] = '{0, 0, 68, 24, 0};

  dir_row_t dir_rows [$];

  tx_queue_partial_completion #(
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    if (n_errors < MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
    end
    n_errors++;
  endtask

  // apply one request to the queue model and return the status it yields
  function automatic tqpc_pkg::out_item_t apply_req(input tqpc_pkg::in_item_t req);
    tqpc_pkg::out_item_t res;
    int                  left;
    int                  rest;
    res = '0;
    res.accepted = 1'b1;
    left = int'(req.byte_count);
    case (req.req_type)
      tqpc_pkg::REQ_ADD: begin
        if (msg_cnt == QDEPTH) begin
          res.accepted = 1'b0;
        end else begin
          msg_len_mem[6'(head_idx + msg_cnt[5:0])] = req.msg_len;
          msg_cnt = msg_cnt + 7'd1;
          unsent_bytes = unsent_bytes + tqpc_pkg::BYTE_W'(req.msg_len);
        end
      end
      tqpc_pkg::REQ_REPORT: begin
        // zero-length heads only go while bytes are left over
        while (msg_cnt != 0 && left > 0) begin
          rest = int'(msg_len_mem[head_idx]) - int'(head_sent);
          if (rest > left) begin
            head_sent = head_sent + tqpc_pkg::LEN_BITS'(left);
            unsent_bytes = unsent_bytes - tqpc_pkg::BYTE_W'(left);
            left = 0;
          end else begin
            left = left - rest;
            unsent_bytes = unsent_bytes - tqpc_pkg::BYTE_W'(rest);
            head_idx = head_idx + 6'd1;
            msg_cnt = msg_cnt - 7'd1;
            head_sent = '0;
            res.released_count = res.released_count + 7'd1;
          end
        end
      end
      tqpc_pkg::REQ_CLEAR: begin
        head_idx = '0;
        msg_cnt = '0;
        head_sent = '0;
        unsent_bytes = '0;
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
    res.queued_count = msg_cnt;
    res.pending_bytes = unsent_bytes;
    res.head_offset_out = head_sent;
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [15:0] len,
                                  input logic [21:0] bytes, input int reps,
                                  input bit typed, input bit acc, input int freed,
                                  input int cnt, input int pend, input int ofs);
    dir_row_t r;
    r.req = '{req_type: kind, msg_len: len, byte_count: bytes};
    r.reps = reps;
    r.typed = typed;
    r.want = '{accepted: acc, released_count: 7'(freed), queued_count: 7'(cnt),
               pending_bytes: tqpc_pkg::BYTE_W'(pend),
               head_offset_out: tqpc_pkg::LEN_BITS'(ofs)};
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // random request shaped by the current queue contents
  function automatic tqpc_pkg::in_item_t random_req(input bit filling);
    tqpc_pkg::in_item_t r;
    int                 roll;
    int                 k;
    int                 acc;
    int                 rest;
    r.byte_count = tqpc_pkg::BYTE_W'($urandom_range(0, int'(BYTE_MAX)));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      r.msg_len = '0;
    end else if (roll < 20) begin
      r.msg_len = '1;
    end else if (roll < 60) begin
      r.msg_len = tqpc_pkg::LEN_BITS'($urandom_range(1, 16));
    end else begin
      r.msg_len = tqpc_pkg::LEN_BITS'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      r.req_type = tqpc_pkg::REQ_CLEAR;
    end else if (roll < 4) begin
      r.req_type = REQ_UNUSED;
    end else if (roll < (filling ? 85 : 40)) begin
      r.req_type = tqpc_pkg::REQ_ADD;
    end else begin
      r.req_type = tqpc_pkg::REQ_REPORT;
      roll = $urandom_range(0, 99);
      rest = int'(msg_len_mem[head_idx]) - int'(head_sent);
      if (roll < 10) begin
        r.byte_count = '0;
      end else if (roll < 40 && msg_cnt != 0) begin
        // exactly the first few messages
        k = $urandom_range(1, (msg_cnt < 4) ? int'(msg_cnt) : 4);
        acc = -int'(head_sent);
        for (int i = 0; i < k; i++) begin
          acc += int'(msg_len_mem[6'(head_idx + i)]);
        end
        r.byte_count = tqpc_pkg::BYTE_W'(acc);
      end else if (roll < 60 && msg_cnt != 0) begin
        r.byte_count = tqpc_pkg::BYTE_W'($urandom_range(1, (rest > 2) ? rest - 1 : 1));
      end else if (roll < 85) begin
        r.byte_count = tqpc_pkg::BYTE_W'($urandom_range(0, int'(unsent_bytes) + 16));
      end
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic drive_req(input tqpc_pkg::in_item_t req);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (status_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : monitor
    tqpc_pkg::out_item_t want;
    bit                  moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        n_status++;
        if (status_q.size() == 0) begin
          report_mismatch("status with no request outstanding, pending_bytes",
                          int'(out_data.pending_bytes), -1);
        end else begin
          want = status_q.pop_front();
          if (out_data.accepted !== want.accepted)
            report_mismatch("accepted", int'(out_data.accepted), int'(want.accepted));
          if (out_data.released_count !== want.released_count)
            report_mismatch("released_count", int'(out_data.released_count),
                            int'(want.released_count));
          if (out_data.queued_count !== want.queued_count)
            report_mismatch("queued_count", int'(out_data.queued_count),
                            int'(want.queued_count));
          if (out_data.pending_bytes !== want.pending_bytes)
            report_mismatch("pending_bytes", int'(out_data.pending_bytes),
                            int'(want.pending_bytes));
          if (out_data.head_offset_out !== want.head_offset_out)
            report_mismatch("head_offset_out", int'(out_data.head_offset_out),
                            int'(want.head_offset_out));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_reqs++;
        want = apply_req(in_data);
        if (in_data.req_type == tqpc_pkg::REQ_ADD && !want.accepted) n_refused++;
        if (in_data.req_type == tqpc_pkg::REQ_REPORT && want.head_offset_out != 0)
          n_partial++;
        if (int'(want.released_count) > max_freed) max_freed = int'(want.released_count);
        if (row_typed) want = row_want;
        status_q.insert(status_q.size(), want);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d status pending",
                 idle_cycles, status_q.size());
        $display("tx_queue_partial_completion verification failed");
        $finish;
      end
    end
  end

  initial begin
    bit filling;
    // empty queue, zero-length heads, oversize reports, full queue
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'h000000, 1, 1, 1, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, BYTE_MAX, 1, 1, 1, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_CLEAR, 16'h0000, 22'h000000, 1, 1, 1, 0, 0, 0, 0);
    add_row(REQ_UNUSED, 16'hFFFF, BYTE_MAX, 1, 1, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'hFFFF, 22'h000000, 1, 1, 1, 0, 1, 65535, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'h0000, BYTE_MAX, 1, 1, 1, 0, 2, 65535, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'h000000, 1, 1, 1, 0, 2, 65535, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'h000001, 1, 1, 1, 0, 2, 65534, 1);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'd65534, 1, 1, 1, 1, 1, 0, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'h000001, 1, 1, 1, 1, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'hFFFF, 22'h000000, QDEPTH, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'h1234, 22'h000000, 1, 1, 0, 0, 64, 4194240, 0);
    add_row(REQ_UNUSED, 16'h0000, 22'h000000, 1, 1, 0, 0, 64, 4194240, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, BYTE_MAX, 1, 1, 1, 64, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'hAAAA, 22'h2AAAAA, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'h5555, 22'h155555, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'hFFFF, 22'h000100, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_CLEAR, 16'hFFFF, BYTE_MAX, 1, 1, 1, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'd3, 22'h000000, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'd0, 22'h000000, 2, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_ADD, 16'd7, 22'h000000, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'd4, 1, 0, 0, 0, 0, 0, 0);
    add_row(tqpc_pkg::REQ_REPORT, 16'h0000, 22'd6, 1, 0, 0, 0, 0, 0, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      for (int n = 0; n < dir_rows[i].reps; n++) begin
        row_typed = dir_rows[i].typed;
        row_want = dir_rows[i].want;
        drive_req(dir_rows[i].req);
      end
    end
    row_typed = 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // hold off until the block has answered everything
      in_valid <= 1'b0;
      wait_drained();
      gap_pct = gap_tab[ph];
      stall_pct = stall_tab[ph];
      filling = 1'b1;
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        if (n % 40 == 39) filling = ~filling;
        drive_req(random_req(filling));
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (LAT_MAX + 10) @(negedge clk);

    $display("run: %0d requests, %0d status transfers, %0d adds refused on a full queue",
             n_reqs, n_status, n_refused);
    $display("run: %0d reports left a partly sent head, up to %0d messages freed at once",
             n_partial, max_freed);
    if (n_errors == 0) begin
      $display("tx_queue_partial_completion verification clean");
    end else begin
      $display("tx_queue_partial_completion verification failed");
    end
    $finish;
  end

endmodule
